// ----- design/psw_pkg.sv -----
// ----------------------------------------------------------------------------
// psw_pkg - shared definitions for the predictive soil watering controller
// Payload structs, controller/datapath command and status groups, register
// indexes, reason codes and the fixed-point constants of the decision logic.
// ----------------------------------------------------------------------------
package psw_pkg;

    // History ring depth default
    localparam int HISTORY_DEPTH_DEF = 16;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int MOIST_W  = 10;
    localparam int TEMP_W   = 12;
    localparam int REASON_W = 3;
    localparam int MIN_W    = 9;
    localparam int QK_W     = $clog2(MIN_W);

    // Configuration port
    localparam int CFG_IDX_W  = 32;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 32'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT    = 32'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS  = 32'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL    = 32'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN    = 32'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE       = 32'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DAILY_LIMIT = 32'd6;

    // Register reset values
    localparam logic               RST_ENABLE      = 1'b1;
    localparam logic [MOIST_W-1:0] RST_SETPOINT    = 10'd600;
    localparam logic [MOIST_W-1:0] RST_HYSTERESIS  = 10'd100;
    localparam logic [TIME_W-1:0]  RST_INTERVAL    = 32'd60000;
    localparam logic [TIME_W-1:0]  RST_COOLDOWN    = 32'd600000;
    localparam logic [TIME_W-1:0]  RST_PULSE       = 32'd5000;
    localparam logic [TIME_W-1:0]  RST_DAILY_LIMIT = 32'd120000;

    // Reason codes
    localparam logic [REASON_W-1:0] REASON_NONE      = 3'd0;
    localparam logic [REASON_W-1:0] REASON_INVALID   = 3'd1;
    localparam logic [REASON_W-1:0] REASON_BLOCKED   = 3'd2;
    localparam logic [REASON_W-1:0] REASON_DRY       = 3'd3;
    localparam logic [REASON_W-1:0] REASON_PREDICTED = 3'd4;
    localparam logic [REASON_W-1:0] REASON_RISING    = 3'd5;

    // Fixed-point constants (moisture 0.1 %, temperature 0.1 C, time ms)
    localparam logic [MOIST_W-1:0]       MOIST_MAX    = 10'd1000;  // setpoint cap
    localparam logic [MOIST_W-1:0]       HYST_MIN     = 10'd10;    // 1 % minimum band
    localparam logic signed [TEMP_W-1:0] COLD_LIMIT   = 12'sd50;   // 5.0 C
    localparam logic [TIME_W-1:0]        TREND_MIN_DT = 32'd540000; // 0.15 h
    localparam logic [19:0]              FALL_K       = 20'd720000; // -0.5 %/h test
    localparam logic [16:0]              RISE_K       = 17'd120000; // 3 %/h test
    localparam logic [24:0]              HORIZON_K    = 25'd21600000; // 6 h
    localparam logic [15:0]              MINUTE_K     = 16'd60000;  // ms per minute

    // Input transaction payload
    typedef struct packed {
        logic [TIME_W-1:0]        now_ms;
        logic                     moisture_valid;
        logic [MOIST_W-1:0]       moisture;
        logic                     soil_temp_valid;
        logic signed [TEMP_W-1:0] soil_temp;
        logic [TIME_W-1:0]        pump_ms_today;
    } t_in;

    // Result transaction payload
    typedef struct packed {
        logic                start_pump;
        logic [REASON_W-1:0] reason;
        logic [MIN_W-1:0]    predicted_minutes;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture input transaction
        logic check;     // gating tests, history store
        logic rd_new;    // read newest sample
        logic rd_old;    // read oldest sample, keep newest
        logic diff;      // time and moisture differences
        logic slope;     // falling / rising tests
        logic mul;       // prediction products
        logic cmp;       // final decision
        logic div_step;  // one quotient bit
        logic finish;    // load result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic early;     // disabled or invalid moisture
        logic blocked;   // cooldown, budget or cold soil
        logic need_div;  // predicted watering, minutes needed
        logic div_last;  // last quotient bit
        logic out_full;  // result register cannot take a new result
    } t_sts;

endpackage

// ----- design/psw_ram.sv -----
// ----------------------------------------------------------------------------
// psw_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/psw_ctrl.sv -----
// ----------------------------------------------------------------------------
// psw_ctrl - sequencer of the watering decision
// Steps the datapath through capture, gating, history reads, slope tests,
// prediction products and the serial minutes division.
// ----------------------------------------------------------------------------
module psw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  psw_pkg::t_sts i_sts,
    output psw_pkg::t_cmd o_cmd
);
    import psw_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_RD_NEW = 4'd2;
    localparam logic [3:0] S_RD_OLD = 4'd3;
    localparam logic [3:0] S_DIFF   = 4'd4;
    localparam logic [3:0] S_SLOPE  = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_CMP    = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.early ? S_FIN : S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.blocked ? S_FIN : S_RD_NEW;
            end
            S_RD_NEW: begin
                o_cmd.rd_new = 1'b1;
                n_state      = S_RD_OLD;
            end
            S_RD_OLD: begin
                o_cmd.rd_old = 1'b1;
                n_state      = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_SLOPE;
            end
            S_SLOPE: begin
                o_cmd.slope = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_sts.need_div ? S_DIV : S_FIN;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = i_sts.div_last ? S_FIN : S_DIV;
            end
            S_FIN: begin
                if (!i_sts.out_full) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/psw_datapath.sv -----
// ----------------------------------------------------------------------------
// psw_datapath - registers, history ring and arithmetic of the controller
// Holds configuration and history state, evaluates gating and trend tests,
// divides for the minutes estimate and keeps the result register.
// ----------------------------------------------------------------------------
module psw_datapath #(
    parameter int HISTORY_DEPTH = psw_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  psw_pkg::t_in                      i_in_data,
    input  psw_pkg::t_cmd                     i_cmd,
    output psw_pkg::t_sts                     o_sts,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output psw_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [psw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [psw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import psw_pkg::*;

    localparam int SW     = $clog2(HISTORY_DEPTH);
    localparam int CW     = $clog2(HISTORY_DEPTH + 1);
    localparam int WORD_W = MOIST_W + TIME_W;
    localparam int NUM_W  = MOIST_W + TIME_W;   // a * dt
    localparam int LIM_W  = MOIST_W + 25;       // b * horizon
    localparam int DIV_W  = MOIST_W + 16;       // b * minute

    // Configuration registers
    logic               r_enable;
    logic [MOIST_W-1:0] r_setpoint;
    logic [MOIST_W-1:0] r_hyst;
    logic [TIME_W-1:0]  r_interval;
    logic [TIME_W-1:0]  r_cooldown;
    logic [TIME_W-1:0]  r_pulse;
    logic [TIME_W-1:0]  r_limit;

    // History bookkeeping
    logic [SW-1:0]      r_slot;
    logic [CW-1:0]      r_count;
    logic [TIME_W-1:0]  r_last_sample;
    logic [TIME_W-1:0]  r_last_pump;

    // Transaction working registers
    t_in                r_in;
    logic [MOIST_W-1:0] r_dry;
    logic [MOIST_W-1:0] r_new_m;
    logic [TIME_W-1:0]  r_new_t;
    logic [TIME_W-1:0]  r_dt;
    logic [MOIST_W-1:0] r_dm_mag;
    logic               r_dm_neg;
    logic               r_dm_pos;
    logic               r_trend;
    logic [MOIST_W-1:0] r_a;
    logic               r_dry_hit;
    logic               r_falling;
    logic               r_rising;
    logic [NUM_W-1:0]   r_num;
    logic [LIM_W-1:0]   r_lim;
    logic [DIV_W-1:0]   r_divisor;
    logic [NUM_W-1:0]   r_rem;
    logic [MIN_W-1:0]   r_quot;
    logic [QK_W-1:0]    r_k;
    logic [REASON_W-1:0] r_reason;
    logic               r_start;
    t_out               r_out;
    logic               r_out_valid;

    // Combinational helpers
    logic [MOIST_W-1:0] sp_cap;
    logic [MOIST_W-1:0] hy_min;
    logic [MOIST_W-1:0] dry_level;
    logic               store_ok;
    logic               cool_ok;
    logic               budget_ok;
    logic               cold;
    logic [SW-1:0]      new_idx;
    logic [SW-1:0]      old_idx;
    logic [CW:0]        slot_ext;
    logic [CW:0]        count_ext;
    logic [WORD_W-1:0]  ram_rdata;
    logic [MOIST_W-1:0] old_m;
    logic [TIME_W-1:0]  old_t;
    logic [TIME_W-1:0]  dt;
    logic [29:0]        fall_prod;
    logic [26:0]        rise_prod;
    logic               predicted;
    logic [NUM_W-1:0]   div_shifted;

    assign o_cfg_ready = 1'b1;

    // Dry threshold: capped setpoint minus raised hysteresis, floored at zero
    always_comb begin
        sp_cap    = (r_setpoint > MOIST_MAX) ? MOIST_MAX : r_setpoint;
        hy_min    = (r_hyst < HYST_MIN) ? HYST_MIN : r_hyst;
        dry_level = (sp_cap > hy_min) ? (sp_cap - hy_min) : '0;
    end

    // Gating tests on the captured transaction
    assign store_ok  = (r_in.now_ms - r_last_sample) >= r_interval;
    assign cool_ok   = (r_in.now_ms - r_last_pump) > r_cooldown;
    assign budget_ok = ({1'b0, r_in.pump_ms_today} + {1'b0, r_pulse}) <= {1'b0, r_limit};
    assign cold      = r_in.soil_temp_valid && (r_in.soil_temp < COLD_LIMIT);

    // Ring indexes of the newest and oldest samples
    assign slot_ext  = (CW + 1)'(r_slot);
    assign count_ext = (CW + 1)'(r_count);
    always_comb begin
        new_idx = (r_slot == '0) ? SW'(HISTORY_DEPTH - 1) : (r_slot - 1'b1);
        if (slot_ext >= count_ext) begin
            old_idx = SW'(slot_ext - count_ext);
        end else begin
            old_idx = SW'(slot_ext + (CW + 1)'(HISTORY_DEPTH) - count_ext);
        end
    end

    // History ring: moisture and timestamp in one word
    psw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.check && store_ok),
        .i_waddr (r_slot),
        .i_wdata ({r_in.moisture, r_in.now_ms}),
        .i_re    (i_cmd.rd_new || i_cmd.rd_old),
        .i_raddr (i_cmd.rd_old ? old_idx : new_idx),
        .o_rdata (ram_rdata)
    );

    assign old_m = ram_rdata[TIME_W +: MOIST_W];
    assign old_t = ram_rdata[TIME_W-1:0];
    assign dt    = r_new_t - old_t;

    // Slope products and prediction test
    assign fall_prod   = 30'(r_dm_mag) * 30'(FALL_K);
    assign rise_prod   = 27'(r_dm_mag) * 27'(RISE_K);
    assign predicted   = r_falling && !r_dry_hit && (r_num < NUM_W'(r_lim));
    assign div_shifted = NUM_W'(r_divisor) << r_k;

    // Status to the controller
    always_comb begin
        o_sts.early    = !r_enable || !i_in_data.moisture_valid;
        o_sts.blocked  = !cool_ok || !budget_ok || cold;
        o_sts.need_div = predicted && !r_rising;
        o_sts.div_last = (r_k == '0);
        o_sts.out_full = r_out_valid && !i_out_ready;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= RST_ENABLE;
            r_setpoint <= RST_SETPOINT;
            r_hyst     <= RST_HYSTERESIS;
            r_interval <= RST_INTERVAL;
            r_cooldown <= RST_COOLDOWN;
            r_pulse    <= RST_PULSE;
            r_limit    <= RST_DAILY_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENABLE:      r_enable   <= i_cfg_data[0];
                CFG_SETPOINT:    r_setpoint <= i_cfg_data[MOIST_W-1:0];
                CFG_HYSTERESIS:  r_hyst     <= i_cfg_data[MOIST_W-1:0];
                CFG_INTERVAL:    r_interval <= i_cfg_data[TIME_W-1:0];
                CFG_COOLDOWN:    r_cooldown <= i_cfg_data[TIME_W-1:0];
                CFG_PULSE:       r_pulse    <= i_cfg_data[TIME_W-1:0];
                CFG_DAILY_LIMIT: r_limit    <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // History pointers and pump timestamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot        <= '0;
            r_count       <= '0;
            r_last_sample <= '0;
            r_last_pump   <= '0;
        end else begin
            if (i_cmd.check && store_ok) begin
                r_last_sample <= r_in.now_ms;
                if (r_count < CW'(HISTORY_DEPTH)) begin
                    r_count <= r_count + 1'b1;
                end
                r_slot <= (r_slot == SW'(HISTORY_DEPTH - 1)) ? '0 : (r_slot + 1'b1);
            end
            if (i_cmd.finish && r_start) begin
                r_last_pump <= r_in.now_ms;
            end
        end
    end

    // Decision pipeline of one transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in    <= i_in_data;
            r_start <= 1'b0;
            r_quot  <= '0;
            if (!r_enable) begin
                r_reason <= REASON_BLOCKED;
            end else if (!i_in_data.moisture_valid) begin
                r_reason <= REASON_INVALID;
            end else begin
                r_reason <= REASON_NONE;
            end
        end
        if (i_cmd.check) begin
            r_dry <= dry_level;
            if (o_sts.blocked) begin
                r_reason <= REASON_BLOCKED;
            end
        end
        if (i_cmd.rd_old) begin
            r_new_m <= ram_rdata[TIME_W +: MOIST_W];
            r_new_t <= ram_rdata[TIME_W-1:0];
        end
        // differences of newest against oldest
        if (i_cmd.diff) begin
            r_dt      <= dt;
            r_dm_neg  <= r_new_m < old_m;
            r_dm_pos  <= r_new_m > old_m;
            r_dm_mag  <= (r_new_m >= old_m) ? (r_new_m - old_m) : (old_m - r_new_m);
            r_trend   <= (r_count >= CW'(2)) && (dt > TREND_MIN_DT);
            r_dry_hit <= r_in.moisture <= r_dry;
            r_a       <= (r_in.moisture > r_dry) ? (r_in.moisture - r_dry) : '0;
        end
        // slope tests by cross-multiplication
        if (i_cmd.slope) begin
            r_falling <= r_trend && r_dm_neg && (TIME_W'(fall_prod) > r_dt);
            r_rising  <= r_trend && r_dm_pos && (TIME_W'(rise_prod) > r_dt);
        end
        if (i_cmd.mul) begin
            r_num     <= NUM_W'(r_a) * NUM_W'(r_dt);
            r_lim     <= LIM_W'(r_dm_mag) * LIM_W'(HORIZON_K);
            r_divisor <= DIV_W'(r_dm_mag) * DIV_W'(MINUTE_K);
        end
        // final reason and division setup
        if (i_cmd.cmp) begin
            r_rem <= r_num;
            r_k   <= QK_W'(MIN_W - 1);
            priority if (r_dry_hit) begin
                r_reason <= r_rising ? REASON_RISING : REASON_DRY;
                r_start  <= !r_rising;
            end else if (predicted) begin
                r_reason <= r_rising ? REASON_RISING : REASON_PREDICTED;
                r_start  <= !r_rising;
            end else begin
                r_reason <= REASON_NONE;
            end
        end
        // restoring division, one quotient bit per step
        if (i_cmd.div_step) begin
            if (r_rem >= div_shifted) begin
                r_rem       <= r_rem - div_shifted;
                r_quot[r_k] <= 1'b1;
            end
            r_k <= r_k - 1'b1;
        end
        if (i_cmd.finish) begin
            r_out.start_pump        <= r_start;
            r_out.reason            <= r_reason;
            r_out.predicted_minutes <= (r_reason == REASON_PREDICTED) ? r_quot : '0;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Ring pointers stay in range
    a_ring_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot <= SW'(HISTORY_DEPTH - 1)) && (r_count <= CW'(HISTORY_DEPTH)))
        else $error("history pointer out of range");

    // A pump start goes only with a dry or predicted reason
    a_start_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.start_pump ==
            ((r_out.reason == REASON_DRY) || (r_out.reason == REASON_PREDICTED))))
        else $error("start_pump inconsistent with reason");

    // Minutes only with a prediction, and then inside six hours
    a_minutes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.reason == REASON_PREDICTED) ?
            (r_out.predicted_minutes < MIN_W'(360)) : (r_out.predicted_minutes == '0)))
        else $error("predicted_minutes out of range");

    // A delivered start records its timestamp for the cooldown
    a_pump_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_start) |=> (r_last_pump == $past(r_in.now_ms)))
        else $error("last pump time not updated");

endmodule

// ----- design/predictive_soil_watering_control.sv -----
// ----------------------------------------------------------------------------
// predictive_soil_watering_control - soil moisture watering decision
// Stores moisture history, applies cooldown, budget and cold-soil blocks and
// decides on a pump pulse from dryness or a predicted drying trend.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one control run
//   per transaction; output channel (o_out_valid / i_out_ready / o_out_data)
//   returns exactly one decision per run. Configuration writes use
//   i_cfg_valid / o_cfg_ready with a register index and data; the port is
//   always ready and is to be written only between runs by the user; the
//   block itself does not enforce this. A disabled or invalid run goes
//   straight to the result step, a blocked run after the gating check;
//   other runs pass the history reads, differences, slope tests, products
//   and decision, then the restoring divider, one minutes bit per cycle,
//   when a minutes estimate is needed. The two history reads share the
//   single RAM read port. One run is in flight at a time; runs are accepted only in idle.
//   A finished result sits in the output register while the next run is
//   accepted; a stalled receiver holds the next result in its last step
//   until the register frees up.
//   Reset (synchronous, active low) restores the register defaults and
//   empties the history; the history RAM itself needs no clearing.
// ----------------------------------------------------------------------------
module predictive_soil_watering_control #(
    parameter int HISTORY_DEPTH = psw_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  psw_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output psw_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [psw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [psw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import psw_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    psw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Registers, history and arithmetic
    psw_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

// ----- verif/psw_decision_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psw_decision_checker - watering decision predictor and result comparison
// Follows the configuration writes and the accepted control runs, works out
// each run's decision from its own copy of the registers and the moisture
// history, and compares every delivered decision field by field, in order.
// ----------------------------------------------------------------------------
module psw_decision_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  psw_pkg::t_in                    i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  psw_pkg::t_out                   i_out_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [psw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [psw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_busy,
    output int                              o_errors
);
    import psw_pkg::*;

    localparam int DEPTH  = HISTORY_DEPTH_DEF;
    localparam int SLOT_W = $clog2(DEPTH);

    // Register copies
    logic               enable_r;
    logic [MOIST_W-1:0] setpoint_r;
    logic [MOIST_W-1:0] hyst_r;
    logic [TIME_W-1:0]  interval_r;
    logic [TIME_W-1:0]  cooldown_r;
    logic [TIME_W-1:0]  pulse_r;
    logic [TIME_W-1:0]  limit_r;

    // Moisture history ring and timing state
    logic [MOIST_W-1:0] hist_m [DEPTH];
    logic [TIME_W-1:0]  hist_t [DEPTH];
    logic [SLOT_W-1:0]  wr_slot;
    logic [SLOT_W:0]    n_samples;
    logic [TIME_W-1:0]  last_sample_ms;
    logic [TIME_W-1:0]  last_pump_ms;

    t_out decisions_due[$];
    int   errors = 0;
    int   decision_no = 0;

    assign o_errors = errors;

    task automatic report_mismatch(input string msg);
        if (errors < 50)
            $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_ENABLE:      enable_r   = val[0];
            CFG_SETPOINT:    setpoint_r = val[MOIST_W-1:0];
            CFG_HYSTERESIS:  hyst_r     = val[MOIST_W-1:0];
            CFG_INTERVAL:    interval_r = val;
            CFG_COOLDOWN:    cooldown_r = val;
            CFG_PULSE:       pulse_r    = val;
            CFG_DAILY_LIMIT: limit_r    = val;
            default: ;
        endcase
    endtask

    // One control run: history update, blocking tests, dry / trend decision
    task automatic predict_run(input t_in run, output t_out res);
        logic [TIME_W-1:0] since;
        logic [TIME_W-1:0] span32;
        logic [SLOT_W-1:0] ni;
        logic [SLOT_W-1:0] oi;
        longint            m;
        longint            sp;
        longint            hy;
        longint            dry;
        longint            dm;
        longint unsigned   dt;
        longint unsigned   a;
        longint unsigned   b;
        longint unsigned   prod;
        longint unsigned   spend;
        longint unsigned   pm;
        bit                cool_ok;
        bit                budget_ok;
        bit                cold;
        bit                falling;
        bit                rising;
        bit                predicted;
        res = '0;
        res.reason = REASON_NONE;
        if (!enable_r) begin
            res.reason = REASON_BLOCKED;
        end else if (!run.moisture_valid) begin
            res.reason = REASON_INVALID;
        end else begin
            // store at most one sample per interval, wrapping time difference
            since = run.now_ms - last_sample_ms;
            if (since >= interval_r) begin
                last_sample_ms  = run.now_ms;
                hist_m[wr_slot] = run.moisture;
                hist_t[wr_slot] = run.now_ms;
                if (n_samples < DEPTH)
                    n_samples++;
                wr_slot++;
            end

            m  = run.moisture;
            sp = setpoint_r;
            if (sp > MOIST_MAX)
                sp = MOIST_MAX;
            hy = hyst_r;
            if (hy < HYST_MIN)
                hy = HYST_MIN;
            dry = sp - hy;
            if (dry < 0)
                dry = 0;

            // blocking conditions
            since     = run.now_ms - last_pump_ms;
            cool_ok   = since > cooldown_r;
            spend     = run.pump_ms_today;
            spend     = spend + pulse_r;
            budget_ok = spend <= limit_r;
            cold      = run.soil_temp_valid && ($signed(run.soil_temp) < COLD_LIMIT);

            if (!cool_ok || !budget_ok || cold) begin
                res.reason = REASON_BLOCKED;
            end else begin
                falling   = 1'b0;
                rising    = 1'b0;
                predicted = 1'b0;
                b         = 0;
                pm        = 0;
                // oldest-to-newest trend
                if (n_samples >= 2) begin
                    ni     = wr_slot - 1'b1;
                    oi     = wr_slot - n_samples[SLOT_W-1:0];
                    span32 = hist_t[ni] - hist_t[oi];
                    dt     = span32;
                    dm     = longint'(hist_m[ni]) - longint'(hist_m[oi]);
                    if (dt > TREND_MIN_DT) begin
                        if (dm < 0) begin
                            b       = -dm;
                            falling = (b * FALL_K) > dt;
                        end
                        if (dm > 0) begin
                            a      = dm;
                            rising = (a * RISE_K) > dt;
                        end
                    end
                end
                // time to reach the dry threshold, six hour horizon
                if (falling && m > dry) begin
                    a    = m - dry;
                    prod = a * dt;
                    if (prod < HORIZON_K * b) begin
                        predicted = 1'b1;
                        pm        = prod / (MINUTE_K * b);
                    end
                end
                if (m <= dry) begin
                    if (rising) begin
                        res.reason = REASON_RISING;
                    end else begin
                        res.reason     = REASON_DRY;
                        res.start_pump = 1'b1;
                    end
                end else if (predicted) begin
                    if (rising) begin
                        res.reason = REASON_RISING;
                    end else begin
                        res.reason            = REASON_PREDICTED;
                        res.start_pump        = 1'b1;
                        res.predicted_minutes = pm[MIN_W-1:0];
                    end
                end
                if (res.start_pump)
                    last_pump_ms = run.now_ms;
            end
        end
    endtask

    // Channel monitor: results first, then register writes and new runs
    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (!i_rst_n) begin
            enable_r       = RST_ENABLE;
            setpoint_r     = RST_SETPOINT;
            hyst_r         = RST_HYSTERESIS;
            interval_r     = RST_INTERVAL;
            cooldown_r     = RST_COOLDOWN;
            pulse_r        = RST_PULSE;
            limit_r        = RST_DAILY_LIMIT;
            wr_slot        = '0;
            n_samples      = '0;
            last_sample_ms = '0;
            last_pump_ms   = '0;
            decisions_due.delete();
            o_busy <= 1'b0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (decisions_due.size() == 0) begin
                    report_mismatch($sformatf("decision with no run outstanding: %p", got));
                end else begin
                    want = decisions_due.pop_front();
                    if (got.start_pump !== want.start_pump)
                        report_mismatch($sformatf("decision %0d start_pump exp %0d got %0d",
                            decision_no, want.start_pump, got.start_pump));
                    if (got.reason !== want.reason)
                        report_mismatch($sformatf("decision %0d reason exp %0d got %0d",
                            decision_no, want.reason, got.reason));
                    if (got.predicted_minutes !== want.predicted_minutes)
                        report_mismatch($sformatf("decision %0d minutes exp %0d got %0d",
                            decision_no, want.predicted_minutes, got.predicted_minutes));
                end
                decision_no++;
            end
            if (i_cfg_valid && i_cfg_ready)
                apply_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready) begin
                predict_run(i_in_data, want);
                decisions_due.push_back(want);
            end
            o_busy <= (decisions_due.size() != 0);
        end
    end

endmodule

// ----- verif/predictive_soil_watering_control_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// predictive_soil_watering_control_test - watering controller testbench
// Drives control runs and register writes into the controller: a directed
// pass over blocking, dry, predicted, rising, disabled and time-wrap cases,
// then random episodes of drifting moisture under random settings, with
// random stalls on both channels. The decision checker reports mismatches.
// ----------------------------------------------------------------------------
module predictive_soil_watering_control_test;
    import psw_pkg::*;

    localparam int          RANDOM_RUNS = 550;
    localparam int          CALM_RUNS   = 60;
    localparam logic [31:0] T0          = 32'd1_000_000;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in                   i_in_data   = '0;
    logic                  i_out_ready = 1'b1;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out                  o_out_data;
    logic                  o_cfg_ready;
    logic                  busy;
    int                    errors;

    bit calm      = 1'b0;
    bit tx_gaps   = 1'b0;
    bit rx_stalls = 1'b0;
    int hold_left = 0;

    predictive_soil_watering_control dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    psw_decision_checker u_decisions (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (busy),
        .o_errors    (errors)
    );

    always #1 i_clk = ~i_clk;

    // Receiver: random bursts of stalls on the result channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b1;
            hold_left   <= 0;
        end else if (hold_left == 0 && !calm && rx_stalls && $urandom_range(0, 7) == 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= $urandom_range(1, 12);
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
        end else begin
            hold_left   <= 0;
            i_out_ready <= 1'b1;
        end
    end

    function automatic t_in make_run(input logic [31:0] now, input bit mv, input int m,
                                     input bit tv, input int t, input logic [31:0] today);
        t_in run;
        run.now_ms          = now;
        run.moisture_valid  = mv;
        run.moisture        = m[MOIST_W-1:0];
        run.soil_temp_valid = tv;
        run.soil_temp       = t[TEMP_W-1:0];
        run.pump_ms_today   = today;
        return run;
    endfunction

    // Mostly inside [lo, hi]; now and then zero or the field maximum
    function automatic logic [31:0] spread(input logic [31:0] lo, input logic [31:0] hi,
                                           input logic [31:0] top);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return top;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // Present one run; valid stays high for a back-to-back follower
    task automatic put_run(input t_in run);
        i_in_valid <= 1'b1;
        i_in_data  <= run;
        do @(posedge i_clk); while (!o_in_ready);
        if (!calm && tx_gaps && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Hold off new runs until every outstanding decision is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Stimulus
    initial begin
        logic [31:0] en, sp, hy, iv, cd, pl, lim;
        logic [31:0] now, today;
        t_in         run;
        int          random_sent;
        int          runs;
        int          level;
        int          dry_level;
        int          trend_kind;
        int          temp;

        random_sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default settings, dry threshold 50.0 %
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        put_run(make_run(T0, 0, 1023, 1, 200, 0));                    // invalid moisture
        put_run(make_run(T0, 1, 520, 1, 200, 0));                     // first sample
        put_run(make_run(T0 + 600000, 1, 510, 1, 200, 0));            // falling, predicted
        put_run(make_run(T0 + 700000, 1, 400, 1, 200, 0));            // in cooldown
        put_run(make_run(T0 + 1200000, 1, 0, 1, 200, 0));             // cooldown boundary
        put_run(make_run(T0 + 1200001, 1, 0, 1, 49, 0));              // cold soil
        put_run(make_run(T0 + 1200002, 1, 0, 1, 50, 0));              // just warm, dry
        put_run(make_run(T0 + 1900000, 1, 0, 0, -2048, 0));           // temp not valid
        put_run(make_run(T0 + 2600000, 1, 1023, 1, 2047, 115000));    // budget exactly met
        put_run(make_run(T0 + 3300000, 1, 1000, 1, 1250, 115001));    // budget exceeded
        put_run(make_run(T0 + 3400000, 1, 700, 1, -400, ALL_ONES));   // budget sum no wrap
        // setpoint above cap, band below minimum: dry yet rising fast
        drain_results();
        set_reg(CFG_SETPOINT, 32'd1023);
        set_reg(CFG_HYSTERESIS, 32'd0);
        put_run(make_run(T0 + 4000000, 1, 990, 1, 300, 0));
        drain_results();
        set_reg(CFG_ENABLE, 32'd0);
        put_run(make_run(T0 + 4800000, 1, 100, 1, 300, 0));           // disabled
        drain_results();
        set_reg(CFG_ENABLE, 32'd1);
        put_run(make_run(32'hFFFF_0000, 1, 500, 1, 300, 0));          // time about to wrap
        put_run(make_run(32'h0009_0000, 1, 480, 1, 300, 0));          // wrapped

        // Random episodes of drifting moisture under random settings
        while (random_sent < RANDOM_RUNS) begin
            drain_results();
            en  = ($urandom_range(0, 7) != 0);
            sp  = spread(300, 800, 1023);
            hy  = spread(0, 150, 1023);
            iv  = spread(20000, 120000, ALL_ONES);
            cd  = spread(0, 1500000, ALL_ONES);
            pl  = spread(0, 20000, ALL_ONES);
            lim = spread(20000, 600000, ALL_ONES);
            set_reg(CFG_ENABLE, en);
            set_reg(CFG_SETPOINT, sp);
            set_reg(CFG_HYSTERESIS, hy);
            set_reg(CFG_INTERVAL, iv);
            set_reg(CFG_COOLDOWN, cd);
            set_reg(CFG_PULSE, pl);
            set_reg(CFG_DAILY_LIMIT, lim);

            tx_gaps    = ($urandom_range(0, 2) != 0);
            rx_stalls  = ($urandom_range(0, 2) != 0);
            dry_level  = ((sp > 1000) ? 1000 : int'(sp)) - ((hy < 10) ? 10 : int'(hy));
            if (dry_level < 0)
                dry_level = 0;
            trend_kind = $urandom_range(0, 7);
            if (trend_kind < 5)
                level = dry_level + $urandom_range(0, 60);
            else
                level = dry_level - $urandom_range(0, 60);
            now  = $urandom();
            runs = $urandom_range(8, 40);

            for (int k = 0; k < runs && random_sent < RANDOM_RUNS; k++) begin
                calm = (random_sent >= RANDOM_RUNS - CALM_RUNS);
                if ($urandom_range(0, 9) == 0) begin
                    // noise: every field unconstrained
                    run = make_run($urandom(), $urandom_range(0, 1), $urandom_range(0, 1023),
                                   $urandom_range(0, 1), $urandom_range(0, 4095), $urandom());
                end else begin
                    case ($urandom_range(0, 15))
                        0:       now = now;
                        1:       now = now + $urandom();
                        default: now = now + $urandom_range(10000, 150000);
                    endcase
                    if (trend_kind < 5)
                        level = level - $urandom_range(0, 6);
                    else if (trend_kind < 7)
                        level = level + $urandom_range(0, 15);
                    else
                        level = level + $urandom_range(0, 40) - 20;
                    if (level < 0)
                        level = 0;
                    if (level > 1023)
                        level = 1023;
                    case ($urandom_range(0, 7))
                        0:       temp = $urandom_range(0, 449) - 400;
                        1:       temp = $urandom_range(0, 4095);
                        default: temp = $urandom_range(50, 400);
                    endcase
                    if ($urandom_range(0, 7) == 0)
                        today = $urandom();
                    else
                        today = $urandom_range(0, lim >> 2);
                    run = make_run(now, $urandom_range(0, 15) != 0, level,
                                   $urandom_range(0, 7) != 0, temp, today);
                end
                put_run(run);
                random_sent++;
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("[predictive_soil_watering_control] OK");
        else
            $display("[predictive_soil_watering_control] ERROR");
        $finish;
    end

    // Run limit
    initial begin
        #600_000;
        $display("[predictive_soil_watering_control] ERROR");
        $finish;
    end

endmodule

// ----- predictive_soil_watering_control.f -----
design/psw_pkg.sv
design/psw_ram.sv
design/psw_ctrl.sv
design/psw_datapath.sv
design/predictive_soil_watering_control.sv
verif/psw_decision_checker.sv
verif/predictive_soil_watering_control_test.sv
